>>> rtl/assert_macros.svh
// Assertion macros for the checker module of the red-eye pixel block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define REP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define REP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rep_pkg.sv
// Types and constants for the red-eye pixel classifier and corrector.
`default_nettype none

package rep_pkg;

  typedef enum logic [1:0] {
    MODE_RGB   = 2'd0,
    MODE_RATIO = 2'd1,
    MODE_HSV   = 2'd2
  } detect_mode_t;

  localparam logic [1:0] DETECT_MODE_RESET = MODE_RGB;

  // Plain RGB thresholds.
  localparam logic [7:0] RGB_RED_MIN = 8'd150;
  localparam logic [7:0] RGB_GB_MAX  = 8'd100;

  // HSV: saturation and value must both exceed this.
  localparam logic [7:0] HSV_SV_MIN = 8'd100;

  // Only a red maximum can give a hue below 10 or above 160. With e = g - b and
  // d = max - min, the rounded hue before wrap lies in 161..189 exactly when
  // 60e >= -39d and 60e < 19d.
  localparam logic signed [15:0] HUE_STEP = 16'sd60;
  localparam logic [13:0]        HUE_LO_K = 14'd39;
  localparam logic [12:0]        HUE_HI_K = 13'd19;

  // Rounded saturation exceeds 100 exactly when 510d >= 201max.
  localparam logic [16:0] SAT_DIFF_K = 17'd510;
  localparam logic [15:0] SAT_MAX_K  = 16'd201;

endpackage

`default_nettype wire

>>> rtl/red_eye_pixel_correct_top.sv
// Red-eye pixel classifier and corrector, three-stage pipeline.
//
// Usage: pixels enter on the in_ channel (valid/ready) with blue, green, red
// and an inside-eye flag. Each pixel is tested for redness by the mode held in
// the detect_mode register (0 RGB thresholds, 1 red ratio, 2 HSV, 3 never red).
// A red pixel inside an eye region leaves as gray, all channels set to
// floor((green + blue) / 2), with out_was_red high; every other pixel leaves
// unchanged. One result per pixel, in order.
// The first stage loads at the accepting edge and out_valid follows from the
// third stage register. Throughput is one pixel per cycle while the receiver
// keeps out_ready high; the three stages are max/min search, the constant
// multiplies, and the compares with mode selection.
// The register is written on the cfg_ channel, which is always ready; write it
// only while no pixel is in flight.
// Reset empties the pipeline and sets the mode to RGB thresholds. When the
// receiver holds out_ready low, the result stays on the outputs and the
// stages behind it keep filling; in_ready falls only once all three are full.
`default_nettype none

module red_eye_pixel_correct_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_blue_in,
  input  wire logic [7:0] in_green_in,
  input  wire logic [7:0] in_red_in,
  input  wire logic       in_inside_eye,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_blue_out,
  output logic [7:0]      out_green_out,
  output logic [7:0]      out_red_out,
  output logic            out_was_red
);
  import rep_pkg::*;

  logic [1:0] mode_r;

  // Stage 1: extremes and simple terms.
  logic              v1_r;
  logic [7:0]        b1_r, g1_r, r1_r;
  logic              ins1_r;
  logic [7:0]        vmax1_r, vmin1_r;
  logic              rmax1_r;
  logic signed [8:0] e1_r;
  logic [8:0]        sum1_r;
  logic              rgb1_r;

  // Stage 2: constant products.
  logic               v2_r;
  logic [7:0]         b2_r, g2_r, r2_r, avg2_r;
  logic               ins2_r;
  logic               rgb2_r, ratio2_r, rmax2_r, vbig2_r;
  logic signed [15:0] e60_2_r;
  logic [13:0]        d39_2_r;
  logic [12:0]        d19_2_r;
  logic [16:0]        d510_2_r;
  logic [15:0]        v201_2_r;

  // Stage 3: output register.
  logic       v3_r;
  logic [7:0] b3_r, g3_r, r3_r;
  logic       red3_r;

  logic rdy1, rdy2, rdy3;

  logic [7:0]        vmax1_nxt, vmin1_nxt;
  logic [7:0]        diff;
  logic [10:0]       gb3;
  logic signed [16:0] hue_lo;
  logic              hue_ok, sat_ok, hsv_hit, hit, fix;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= DETECT_MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  always_comb begin
    vmax1_nxt = in_red_in;
    vmin1_nxt = in_red_in;
    if (in_green_in > vmax1_nxt) vmax1_nxt = in_green_in;
    if (in_blue_in > vmax1_nxt) vmax1_nxt = in_blue_in;
    if (in_green_in < vmin1_nxt) vmin1_nxt = in_green_in;
    if (in_blue_in < vmin1_nxt) vmin1_nxt = in_blue_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      b1_r    <= in_blue_in;
      g1_r    <= in_green_in;
      r1_r    <= in_red_in;
      ins1_r  <= in_inside_eye;
      vmax1_r <= vmax1_nxt;
      vmin1_r <= vmin1_nxt;
      // Ties for the maximum go to red.
      rmax1_r <= (vmax1_nxt == in_red_in);
      e1_r    <= $signed({1'b0, in_green_in}) - $signed({1'b0, in_blue_in});
      sum1_r  <= {1'b0, in_green_in} + {1'b0, in_blue_in};
      rgb1_r  <= (in_red_in > RGB_RED_MIN) && (in_green_in < RGB_GB_MAX) &&
                 (in_blue_in < RGB_GB_MAX);
    end
  end

  assign diff = vmax1_r - vmin1_r;
  assign gb3  = {2'b00, sum1_r} + {1'b0, sum1_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      b2_r     <= b1_r;
      g2_r     <= g1_r;
      r2_r     <= r1_r;
      ins2_r   <= ins1_r;
      avg2_r   <= sum1_r[8:1];
      rgb2_r   <= rgb1_r;
      // 5r > 3(r+g+b) reduces to 2r > 3(g+b).
      ratio2_r <= {2'b00, r1_r, 1'b0} > gb3;
      rmax2_r  <= rmax1_r;
      vbig2_r  <= vmax1_r > HSV_SV_MIN;
      e60_2_r  <= $signed({{7{e1_r[8]}}, e1_r}) * HUE_STEP;
      d39_2_r  <= {6'd0, diff} * HUE_LO_K;
      d19_2_r  <= {5'd0, diff} * HUE_HI_K;
      d510_2_r <= {9'd0, diff} * SAT_DIFF_K;
      v201_2_r <= {8'd0, vmax1_r} * SAT_MAX_K;
    end
  end

  always_comb begin
    hue_lo  = {e60_2_r[15], e60_2_r} + $signed({3'b000, d39_2_r});
    hue_ok  = !hue_lo[16] && (e60_2_r < $signed({3'b000, d19_2_r}));
    sat_ok  = d510_2_r >= {1'b0, v201_2_r};
    hsv_hit = rmax2_r && hue_ok && sat_ok && vbig2_r;
    unique case (mode_r)
      MODE_RGB:   hit = rgb2_r;
      MODE_RATIO: hit = ratio2_r;
      MODE_HSV:   hit = hsv_hit;
      default:    hit = 1'b0;
    endcase
    fix = hit && ins2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      b3_r   <= fix ? avg2_r : b2_r;
      g3_r   <= fix ? avg2_r : g2_r;
      r3_r   <= fix ? avg2_r : r2_r;
      red3_r <= fix;
    end
  end

  assign out_valid     = v3_r;
  assign out_blue_out  = b3_r;
  assign out_green_out = g3_r;
  assign out_red_out   = r3_r;
  assign out_was_red   = red3_r;

endmodule

`default_nettype wire

>>> rtl/rep_checker.sv
// Port-level assertions for the red-eye pixel block, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module rep_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_blue_out,
  input wire logic [7:0] out_green_out,
  input wire logic [7:0] out_red_out,
  input wire logic       out_was_red
);

  // A corrected pixel is gray.
  `REP_ASSERT(a_gray, out_valid && out_was_red |-> out_red_out == out_green_out && out_green_out == out_blue_out, "corrected pixel is not gray")

  // With no result waiting, the pipeline cannot be full.
  `REP_ASSERT(a_ready, !out_valid |-> in_ready, "input stalled with empty output")

  // A held result stays put.
  `REP_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out) && $stable(out_was_red), "held result changed")

  // Reset empties the pipeline.
  `REP_ASSERT_RST(a_reset, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind red_eye_pixel_correct_top rep_checker u_rep_checker (.*);

`default_nettype wire

>>> sim/red_eye_pixel_checker.sv
// Scoreboard for the red-eye pixel block: predicts each corrected pixel and compares it.
`timescale 1ns / 1ps

module red_eye_pixel_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_red_in,
  input  logic       in_inside_eye,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_blue_out,
  input  logic [7:0] out_green_out,
  input  logic [7:0] out_red_out,
  input  logic       out_was_red,
  output int         mismatches,
  output int         outstanding,
  output int         checked,
  output int         grayed
);
  import rep_pkg::*;

  // Hue window for red and the 0.6 red share written as 3/5.
  localparam int unsigned HUE_RED_LOW  = 10;
  localparam int unsigned HUE_RED_HIGH = 160;
  localparam int unsigned RATIO_NUM    = 5;
  localparam int unsigned RATIO_DEN    = 3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       was_red;
  } pixel_out_t;

  logic [1:0] mode_q;
  pixel_out_t pending_pixels[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
    grayed      = 0;
  end

  function automatic bit hsv_says_red(int unsigned bb, int unsigned gg, int unsigned rr);
    int unsigned vmax, vmin, diff, sat, hue, scaled;
    vmax = rr;
    vmin = rr;
    if (gg > vmax) vmax = gg;
    if (bb > vmax) vmax = bb;
    if (gg < vmin) vmin = gg;
    if (bb < vmin) vmin = bb;
    diff = vmax - vmin;
    sat = (vmax == 0) ? 0 : (510 * diff + vmax) / (2 * vmax);
    if (diff == 0) begin
      hue = 0;
    end else begin
      // Ties for the maximum resolve to red, then green, then blue.
      if (vmax == rr) begin
        scaled = 30 * gg + 180 * diff - 30 * bb;
      end else if (vmax == gg) begin
        scaled = 30 * bb + 60 * diff - 30 * rr;
      end else begin
        scaled = 30 * rr + 120 * diff - 30 * gg;
      end
      hue = (2 * scaled + diff) / (2 * diff);
      if (hue >= 180) hue -= 180;
    end
    return (hue < HUE_RED_LOW || hue > HUE_RED_HIGH) && sat > HSV_SV_MIN && vmax > HSV_SV_MIN;
  endfunction

  function automatic pixel_out_t corrected_pixel(logic [1:0] mode, logic [7:0] b,
                                                 logic [7:0] g, logic [7:0] r, logic eye);
    int unsigned bb, gg, rr, avg;
    bit         is_red;
    pixel_out_t px;
    bb = b;
    gg = g;
    rr = r;
    case (mode)
      MODE_RGB:   is_red = rr > RGB_RED_MIN && gg < RGB_GB_MAX && bb < RGB_GB_MAX;
      MODE_RATIO: is_red = RATIO_NUM * rr > RATIO_DEN * (rr + gg + bb);
      MODE_HSV:   is_red = hsv_says_red(bb, gg, rr);
      default:    is_red = 1'b0;
    endcase
    if (is_red && eye) begin
      avg = (gg + bb) >> 1;
      px.blue    = avg[7:0];
      px.green   = avg[7:0];
      px.red     = avg[7:0];
      px.was_red = 1'b1;
    end else begin
      px.blue    = b;
      px.green   = g;
      px.red     = r;
      px.was_red = 1'b0;
    end
    return px;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst_n) begin
      mode_q <= DETECT_MODE_RESET;
      pending_pixels.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_q <= cfg_data;
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %0d/%0d/%0d/%0d",
                   $time, out_blue_out, out_green_out, out_red_out, out_was_red);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("blue_out", want.blue, out_blue_out);
          check_field("green_out", want.green, out_green_out);
          check_field("red_out", want.red, out_red_out);
          check_field("was_red", want.was_red, out_was_red);
          checked++;
          if (want.was_red) grayed++;
        end
      end
      if (in_valid && in_ready) begin
        pending_pixels.push_back(corrected_pixel(mode_q, in_blue_in, in_green_in, in_red_in,
                                                 in_inside_eye));
      end
      outstanding <= pending_pixels.size();
    end
  end

endmodule

>>> sim/tb_red_eye_pixel_correct_top.sv
// Testbench top for the red-eye pixel block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_red_eye_pixel_correct_top;
  import rep_pkg::*;

  localparam logic [1:0] MODE_NEVER       = 2'd3;
  localparam int         RANDOM_PER_PHASE = 165;
  localparam int         LONG_HOLD        = 150;
  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         PHASES           = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_blue_in;
  logic [7:0] in_green_in;
  logic [7:0] in_red_in;
  logic       in_inside_eye;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_blue_out;
  logic [7:0] out_green_out;
  logic [7:0] out_red_out;
  logic       out_was_red;

  int mismatches;
  int outstanding;
  int checked;
  int grayed;
  int sent;
  int cycle_count;

  red_eye_pixel_correct_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .in_inside_eye (in_inside_eye),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_was_red   (out_was_red)
  );

  red_eye_pixel_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .in_inside_eye (in_inside_eye),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_was_red   (out_was_red),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked),
    .grayed        (grayed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("red_eye_pixel_correct_top test failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input logic eye);
    int gap;
    // Every fourth run of 50 pixels goes back to back.
    gap = ((sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_blue_in    <= b;
    in_green_in   <= g;
    in_red_in     <= r;
    in_inside_eye <= eye;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    int b, g, r, lo;
    logic eye;
    eye = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end
      1: begin
        // Red dominant.
        r = $urandom_range(100, 255);
        g = $urandom_range(0, r);
        b = $urandom_range(0, r / 2);
      end
      2: begin
        // Around the RGB thresholds.
        r = $urandom_range(130, 170);
        g = $urandom_range(80, 120);
        b = $urandom_range(80, 120);
      end
      default: begin
        // Red maximum with green and blue close together, near the hue and saturation edges.
        r  = $urandom_range(90, 255);
        lo = $urandom_range(0, r);
        g  = $urandom_range(lo, lo + (r - lo) / 3);
        b  = $urandom_range(lo, lo + (r - lo) / 3);
      end
    endcase
    send_pixel(b[7:0], g[7:0], r[7:0], eye);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed(input logic [1:0] mode);
    case (mode)
      MODE_RGB: begin
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd99, 8'd99, 8'd151, 1'b1);
        send_pixel(8'd99, 8'd99, 8'd150, 1'b1);
        send_pixel(8'd100, 8'd99, 8'd255, 1'b1);
        send_pixel(8'd99, 8'd100, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      end
      MODE_RATIO: begin
        // A zero sum is never red; 3:1:1 sits exactly on the ratio and is not red.
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd1, 8'd1, 8'd3, 1'b1);
        send_pixel(8'd1, 8'd1, 8'd4, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd1, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      end
      MODE_HSV: begin
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd100, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd101, 1'b1);
        send_pixel(8'd101, 8'd101, 8'd101, 1'b1);
        send_pixel(8'd20, 8'd0, 8'd255, 1'b1);
      end
      default: begin
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      end
    endcase
  endtask

  // Result side: random stalls per result, two long hold-offs to back the pipeline up.
  initial begin : sink
    int hold, taken;
    taken = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 250 || taken == 650) begin
        hold = LONG_HOLD;
      end else if ((taken / 40) % 4 == 1) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 13);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    logic [1:0] phase_mode[PHASES];
    phase_mode = '{MODE_RGB, MODE_RATIO, MODE_HSV, MODE_NEVER, MODE_HSV, MODE_RGB};
    sent          = 0;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= DETECT_MODE_RESET;
    in_valid      <= 1'b0;
    in_blue_in    <= '0;
    in_green_in   <= '0;
    in_red_in     <= '0;
    in_inside_eye <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_mode(phase_mode[p]);
      if (p < 4) run_directed(phase_mode[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random();
    end
    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d pixels across RGB, ratio, HSV and disabled detection; %0d recolored.",
             checked, grayed);
    $display("Random stalls on both sides, with two long sink hold-offs of %0d cycles.",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("red_eye_pixel_correct_top test passed");
    end else begin
      $display("red_eye_pixel_correct_top test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rep_pkg.sv
rtl/red_eye_pixel_correct_top.sv
rtl/rep_checker.sv
sim/red_eye_pixel_checker.sv
sim/tb_red_eye_pixel_correct_top.sv
